[hdl/pnt_pkg.sv]
// Shared constants, types and the permutation table of the Perlin noise tile classifier.
`timescale 1ns / 1ps

package pnt_pkg;

  // Coordinate and fraction precision.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 12;

  // Field and register widths.
  localparam int TILE_W      = 16;
  localparam int SCALE_W     = 16;
  localparam int LIMIT_W     = 16;
  localparam int NOISE_W     = 16;
  localparam int CLASS_W     = 2;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 2;

  // Internal fixed-point formats.
  localparam int SCALE_FRAC = 12;
  localparam int Q16_W      = 16;
  localparam int CELL_W     = 8;
  localparam int COORD_USE  = (COORD_BITS < TILE_W) ? COORD_BITS : TILE_W;
  localparam int POS_W      = COORD_USE + SCALE_W;
  localparam int FADE_W     = Q16_W + 1;
  localparam int OFS_W      = Q16_W + 1;
  localparam int GRAD_W     = OFS_W + 2;
  localparam int DIFF_W     = GRAD_W + 1;
  localparam int HASH_W     = 3;

  // Keeps the top FRAC_BITS bits of a Q0.16 fraction.
  localparam logic [Q16_W-1:0] FRAC_MASK = {Q16_W{1'b1}} << (Q16_W - FRAC_BITS);

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_NOISE_SCALE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MID_LIMIT   = 2'd2;

  // Register reset values.
  localparam logic [SCALE_W-1:0] NOISE_SCALE_RESET = 16'd410;
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET   = 16'd19661;
  localparam logic [LIMIT_W-1:0] MID_LIMIT_RESET   = 16'd39322;

  // Terrain classes.
  localparam logic [CLASS_W-1:0] CLASS_WATER = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_DIRT  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_GRASS = 2'd2;

  // Pipeline stages, one load enable each.
  localparam int NUM_STAGES = 10;
  localparam int ST_POS     = 0;
  localparam int ST_LOC     = 1;
  localparam int ST_T2      = 2;
  localparam int ST_T3      = 3;
  localparam int ST_T4      = 4;
  localparam int ST_T5      = 5;
  localparam int ST_FADE    = 6;
  localparam int ST_LERPX   = 7;
  localparam int ST_LERPY   = 8;
  localparam int ST_OUT     = 9;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef struct packed {
    logic [TILE_W-1:0] tile_x;
    logic [TILE_W-1:0] tile_y;
  } sample_t;

  typedef struct packed {
    logic [NOISE_W-1:0] noise_value;
    logic [CLASS_W-1:0] tile_class;
  } result_t;

  // Reference permutation; indexes wrap modulo 256, so the table is not doubled.
  localparam logic [CELL_W-1:0] PERM [256] = '{
    151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,
    140,36,103,30,69,142,8,99,37,240,21,10,23,190,6,148,
    247,120,234,75,0,26,197,62,94,252,219,203,117,35,11,32,
    57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,
    74,165,71,134,139,48,27,166,77,146,158,231,83,111,229,122,
    60,211,133,230,220,105,92,41,55,46,245,40,244,102,143,54,
    65,25,63,161,1,216,80,73,209,76,132,187,208,89,18,169,
    200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,
    52,217,226,250,124,123,5,202,38,147,118,126,255,82,85,212,
    207,206,59,227,47,16,58,17,182,189,28,42,223,183,170,213,
    119,248,152,2,44,154,163,70,221,153,101,155,167,43,172,9,
    129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,
    218,246,97,228,251,34,242,193,238,210,144,12,191,179,162,241,
    81,51,145,235,249,14,239,107,49,192,214,31,181,199,106,157,
    184,84,204,176,115,121,50,45,127,4,150,254,138,236,205,93,
    222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180
  };

endpackage

[hdl/pnt_locate.sv]
// Coordinate scaling, lattice cell and fraction split, first permutation lookup.
`timescale 1ns / 1ps

module pnt_locate import pnt_pkg::*; (
  input  logic               clk,
  input  stage_en_t          en,
  input  sample_t            sample,
  input  logic [SCALE_W-1:0] noise_scale,
  output logic [Q16_W-1:0]   frac_x,
  output logic [Q16_W-1:0]   frac_y,
  output logic [CELL_W-1:0]  cell_y,
  output logic [CELL_W-1:0]  perm_x0,
  output logic [CELL_W-1:0]  perm_x1
);

  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [CELL_W-1:0] cx;
  logic [CELL_W-1:0] cx1;
  logic [CELL_W-1:0] cy;
  logic [Q16_W-1:0]  fx;
  logic [Q16_W-1:0]  fy;

  always_ff @(posedge clk) begin
    if (en[ST_POS]) begin
      pos_x <= sample.tile_x[COORD_USE-1:0] * noise_scale;
      pos_y <= sample.tile_y[COORD_USE-1:0] * noise_scale;
    end
  end

  // The fraction keeps its top FRAC_BITS bits, placed in Q0.16.
  always_comb begin
    cx  = pos_x[SCALE_FRAC +: CELL_W];
    cy  = pos_y[SCALE_FRAC +: CELL_W];
    cx1 = cx + CELL_W'(1);
    fx  = {pos_x[SCALE_FRAC-1:0], {(Q16_W-SCALE_FRAC){1'b0}}} & FRAC_MASK;
    fy  = {pos_y[SCALE_FRAC-1:0], {(Q16_W-SCALE_FRAC){1'b0}}} & FRAC_MASK;
  end

  always_ff @(posedge clk) begin
    if (en[ST_LOC]) begin
      frac_x  <= fx;
      frac_y  <= fy;
      cell_y  <= cy;
      perm_x0 <= PERM[cx];
      perm_x1 <= PERM[cx1];
    end
  end

endmodule

[hdl/pnt_fade.sv]
// Quintic fade curve as a chain of registered 16 by 16 multiplies.
`timescale 1ns / 1ps

module pnt_fade import pnt_pkg::*; (
  input  logic              clk,
  input  stage_en_t         en,
  input  logic [Q16_W-1:0]  t,
  output logic [FADE_W-1:0] fade
);

  localparam int SUM_W = 22;

  logic [Q16_W-1:0] t2;
  logic [Q16_W-1:0] t3;
  logic [Q16_W-1:0] t4;
  logic [Q16_W-1:0] t5;
  logic [Q16_W-1:0] t_a;
  logic [Q16_W-1:0] t_b;
  logic [Q16_W-1:0] t_c;
  logic [Q16_W-1:0] t3_b;
  logic [Q16_W-1:0] t3_c;
  logic [Q16_W-1:0] t4_b;
  logic signed [SUM_W-1:0] poly;
  logic [FADE_W-1:0] fade_next;

  function automatic logic [Q16_W-1:0] mul_hi(input logic [Q16_W-1:0] a,
                                              input logic [Q16_W-1:0] b);
    logic [2*Q16_W-1:0] p;
    p = a * b;
    return p[2*Q16_W-1:Q16_W];
  endfunction

  always_ff @(posedge clk) begin
    if (en[ST_T2]) begin
      t2  <= mul_hi(t, t);
      t_a <= t;
    end
    if (en[ST_T3]) begin
      t3  <= mul_hi(t2, t_a);
      t_b <= t_a;
    end
    if (en[ST_T4]) begin
      t4   <= mul_hi(t3, t_b);
      t_c  <= t_b;
      t3_b <= t3;
    end
    if (en[ST_T5]) begin
      t5   <= mul_hi(t4, t_c);
      t4_b <= t4;
      t3_c <= t3_b;
    end
    if (en[ST_FADE]) begin
      fade <= fade_next;
    end
  end

  // 10 t^3 - 15 t^4 + 6 t^5, clamped to 0..1.
  always_comb begin
    poly = 22'sd10 * $signed({6'd0, t3_c}) - 22'sd15 * $signed({6'd0, t4_b})
         + 22'sd6 * $signed({6'd0, t5});
    if (poly[SUM_W-1]) begin
      fade_next = '0;
    end else if (poly > $signed(SUM_W'(1) << Q16_W)) begin
      fade_next = FADE_W'(1) << Q16_W;
    end else begin
      fade_next = poly[FADE_W-1:0];
    end
  end

endmodule

[hdl/pnt_grad.sv]
// Corner hashing and gradient dot products, delayed to meet the fade values.
`timescale 1ns / 1ps

module pnt_grad import pnt_pkg::*; (
  input  logic                     clk,
  input  stage_en_t                en,
  input  logic [Q16_W-1:0]         frac_x,
  input  logic [Q16_W-1:0]         frac_y,
  input  logic [CELL_W-1:0]        cell_y,
  input  logic [CELL_W-1:0]        perm_x0,
  input  logic [CELL_W-1:0]        perm_x1,
  output logic signed [GRAD_W-1:0] grad_aa,
  output logic signed [GRAD_W-1:0] grad_ab,
  output logic signed [GRAD_W-1:0] grad_ba,
  output logic signed [GRAD_W-1:0] grad_bb
);

  logic [CELL_W-1:0] idx_aa;
  logic [CELL_W-1:0] idx_ab;
  logic [CELL_W-1:0] idx_ba;
  logic [CELL_W-1:0] idx_bb;
  logic [CELL_W-1:0] perm_aa;
  logic [CELL_W-1:0] perm_ab;
  logic [CELL_W-1:0] perm_ba;
  logic [CELL_W-1:0] perm_bb;
  logic [HASH_W-1:0] h_aa;
  logic [HASH_W-1:0] h_ab;
  logic [HASH_W-1:0] h_ba;
  logic [HASH_W-1:0] h_bb;
  logic [Q16_W-1:0]  fx;
  logic [Q16_W-1:0]  fy;
  logic signed [OFS_W-1:0] dx0;
  logic signed [OFS_W-1:0] dx1;
  logic signed [OFS_W-1:0] dy0;
  logic signed [OFS_W-1:0] dy1;
  logic signed [GRAD_W-1:0] g4 [4];
  logic signed [GRAD_W-1:0] g5 [4];
  logic signed [GRAD_W-1:0] g6 [4];
  logic signed [GRAD_W-1:0] g7 [4];

  // One of the four diagonal directions (+-1,+-1) per hash; h[2] swaps the roles of dx and dy.
  function automatic logic signed [GRAD_W-1:0] corner_grad(
      input logic [HASH_W-1:0] h,
      input logic signed [OFS_W-1:0] dx,
      input logic signed [OFS_W-1:0] dy);
    logic signed [GRAD_W-1:0] u;
    logic signed [GRAD_W-1:0] v;
    u = h[2] ? GRAD_W'(dy) : GRAD_W'(dx);
    v = h[2] ? GRAD_W'(dx) : GRAD_W'(dy);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  always_comb begin
    idx_aa  = perm_x0 + cell_y;
    idx_ab  = perm_x0 + cell_y + CELL_W'(1);
    idx_ba  = perm_x1 + cell_y;
    idx_bb  = perm_x1 + cell_y + CELL_W'(1);
    perm_aa = PERM[idx_aa];
    perm_ab = PERM[idx_ab];
    perm_ba = PERM[idx_ba];
    perm_bb = PERM[idx_bb];
    // The far-corner offset is the fraction minus one, which is the
    // fraction with a set sign bit.
    dx0 = $signed({1'b0, fx});
    dx1 = $signed({1'b1, fx});
    dy0 = $signed({1'b0, fy});
    dy1 = $signed({1'b1, fy});
  end

  always_ff @(posedge clk) begin
    if (en[ST_T2]) begin
      h_aa <= perm_aa[HASH_W-1:0];
      h_ab <= perm_ab[HASH_W-1:0];
      h_ba <= perm_ba[HASH_W-1:0];
      h_bb <= perm_bb[HASH_W-1:0];
      fx   <= frac_x;
      fy   <= frac_y;
    end
    if (en[ST_T3]) begin
      g4[0] <= corner_grad(h_aa, dx0, dy0);
      g4[1] <= corner_grad(h_ab, dx0, dy1);
      g4[2] <= corner_grad(h_ba, dx1, dy0);
      g4[3] <= corner_grad(h_bb, dx1, dy1);
    end
    if (en[ST_T4]) begin
      g5 <= g4;
    end
    if (en[ST_T5]) begin
      g6 <= g5;
    end
    if (en[ST_FADE]) begin
      g7 <= g6;
    end
  end

  assign grad_aa = g7[0];
  assign grad_ab = g7[1];
  assign grad_ba = g7[2];
  assign grad_bb = g7[3];

endmodule

[hdl/pnt_blend.sv]
// Bilinear blend of the corner gradients, normalization and terrain class.
`timescale 1ns / 1ps

module pnt_blend import pnt_pkg::*; (
  input  logic                     clk,
  input  stage_en_t                en,
  input  logic signed [GRAD_W-1:0] grad_aa,
  input  logic signed [GRAD_W-1:0] grad_ab,
  input  logic signed [GRAD_W-1:0] grad_ba,
  input  logic signed [GRAD_W-1:0] grad_bb,
  input  logic [FADE_W-1:0]        fade_u,
  input  logic [FADE_W-1:0]        fade_v,
  input  logic [LIMIT_W-1:0]       low_limit,
  input  logic [LIMIT_W-1:0]       mid_limit,
  output result_t                  result
);

  localparam int PROD_W = FADE_W + 1 + DIFF_W;
  localparam int STEP_W = PROD_W - Q16_W;
  localparam int NORM_W = GRAD_W + 1;

  logic signed [GRAD_W-1:0] g0;
  logic signed [GRAD_W-1:0] g1;
  logic signed [GRAD_W-1:0] res;
  logic [FADE_W-1:0]        v_d;
  logic signed [NORM_W-1:0] norm;
  result_t                  result_next;

  // a + floor(t * (b - a) / 2^16); the arithmetic shift rounds down.
  function automatic logic signed [GRAD_W-1:0] lerp(input logic signed [GRAD_W-1:0] a,
                                                    input logic signed [GRAD_W-1:0] b,
                                                    input logic [FADE_W-1:0] t);
    logic signed [DIFF_W-1:0] d;
    logic signed [PROD_W-1:0] p;
    logic [STEP_W-1:0]        q;
    logic [STEP_W-1:0]        s;
    d = $signed({b[GRAD_W-1], b}) - $signed({a[GRAD_W-1], a});
    p = $signed({1'b0, t}) * d;
    q = p[PROD_W-1:Q16_W];
    s = {{(STEP_W-GRAD_W){a[GRAD_W-1]}}, a} + q;
    return s[GRAD_W-1:0];
  endfunction

  always_comb begin
    norm = $signed({res[GRAD_W-1], res}) + $signed(NORM_W'(1) << Q16_W);
    if (norm[NORM_W-1]) begin
      result_next.noise_value = '0;
    end else if (|norm[NORM_W-1:NOISE_W+1]) begin
      result_next.noise_value = '1;
    end else begin
      result_next.noise_value = norm[NOISE_W:1];
    end
    if (result_next.noise_value < low_limit) begin
      result_next.tile_class = CLASS_WATER;
    end else if (result_next.noise_value < mid_limit) begin
      result_next.tile_class = CLASS_DIRT;
    end else begin
      result_next.tile_class = CLASS_GRASS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_LERPX]) begin
      g0  <= lerp(grad_aa, grad_ba, fade_u);
      g1  <= lerp(grad_ab, grad_bb, fade_u);
      v_d <= fade_v;
    end
    if (en[ST_LERPY]) begin
      res <= lerp(g0, g1, v_d);
    end
    if (en[ST_OUT]) begin
      result <= result_next;
    end
  end

endmodule

[hdl/perlin_noise_tile_classifier.sv]
// Top level of the Perlin noise tile classifier: control, registers and pipeline.
`timescale 1ns / 1ps

// Usage. Each transfer on the sample channel (sample_valid high, sample_stall
// low) carries one tile coordinate pair. The block returns exactly one
// transfer on the result channel for it: the Q0.16 noise value and the
// terrain class (water, dirt or grass), in the order the samples came in.
// The datapath is a ten-stage pipeline: coordinate scaling, cell split with
// the first permutation lookup, four stages of the fade multiplier chain
// (which also hash the corners and form the gradients), the fade polynomial,
// the horizontal blend, the vertical blend, and the output register with
// normalization and classification. result_valid rises when the sample
// reaches the output register; one sample can be taken in every cycle
// while sample_stall is low, and the fade multiplier chain sets the
// depth.
// When result_stall is high the output register holds its result, and the
// stages behind it keep filling until the first occupied stage meets a
// full one; sample_stall rises only when stage one cannot move.
// Configuration writes land on the cycle cfg_write is high; they are meant
// to happen while the pipeline is empty. Index three is ignored.
// Reset (synchronous, rst high) empties the pipeline and loads the default
// scale and limits; the permutation table is a constant and needs no load.

module perlin_noise_tile_classifier import pnt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  sample_t                sample_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic [SCALE_W-1:0] noise_scale;
  logic [LIMIT_W-1:0] low_limit;
  logic [LIMIT_W-1:0] mid_limit;

  // One valid bit per stage; a stage loads whenever it is empty or its
  // content moves on, so bubbles close up behind a stalled output.
  stage_en_t valid;
  stage_en_t ready;

  logic [Q16_W-1:0]  frac_x;
  logic [Q16_W-1:0]  frac_y;
  logic [CELL_W-1:0] cell_y;
  logic [CELL_W-1:0] perm_x0;
  logic [CELL_W-1:0] perm_x1;
  logic [FADE_W-1:0] fade_u;
  logic [FADE_W-1:0] fade_v;
  logic signed [GRAD_W-1:0] grad_aa;
  logic signed [GRAD_W-1:0] grad_ab;
  logic signed [GRAD_W-1:0] grad_ba;
  logic signed [GRAD_W-1:0] grad_bb;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_scale <= NOISE_SCALE_RESET;
      low_limit   <= LOW_LIMIT_RESET;
      mid_limit   <= MID_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NOISE_SCALE: noise_scale <= cfg_data[SCALE_W-1:0];
        REG_LOW_LIMIT:   low_limit   <= cfg_data[LIMIT_W-1:0];
        REG_MID_LIMIT:   mid_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage load enables, from the output back to the input.
  always_comb begin
    ready[ST_OUT] = !valid[ST_OUT] || !result_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= sample_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign sample_stall = !ready[0];
  assign result_valid = valid[ST_OUT];

  pnt_locate u_locate (
    .clk         (clk),
    .en          (ready),
    .sample      (sample_data),
    .noise_scale (noise_scale),
    .frac_x      (frac_x),
    .frac_y      (frac_y),
    .cell_y      (cell_y),
    .perm_x0     (perm_x0),
    .perm_x1     (perm_x1)
  );

  pnt_fade u_fade_x (
    .clk  (clk),
    .en   (ready),
    .t    (frac_x),
    .fade (fade_u)
  );

  pnt_fade u_fade_y (
    .clk  (clk),
    .en   (ready),
    .t    (frac_y),
    .fade (fade_v)
  );

  pnt_grad u_grad (
    .clk     (clk),
    .en      (ready),
    .frac_x  (frac_x),
    .frac_y  (frac_y),
    .cell_y  (cell_y),
    .perm_x0 (perm_x0),
    .perm_x1 (perm_x1),
    .grad_aa (grad_aa),
    .grad_ab (grad_ab),
    .grad_ba (grad_ba),
    .grad_bb (grad_bb)
  );

  pnt_blend u_blend (
    .clk       (clk),
    .en        (ready),
    .grad_aa   (grad_aa),
    .grad_ab   (grad_ab),
    .grad_ba   (grad_ba),
    .grad_bb   (grad_bb),
    .fade_u    (fade_u),
    .fade_v    (fade_v),
    .low_limit (low_limit),
    .mid_limit (mid_limit),
    .result    (result_data)
  );

endmodule
